// File: rtl/atrp_pkg.sv
// Package with shared types, constants and the arctangent table for the tilt pipeline.
package atrp_pkg;

  localparam int SQ_STEPS = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int DIV_BITS = 15;
  localparam int TILT_LAT = 3 + SQ_STEPS + CORDIC_STEPS + 1 + DIV_BITS + 1;

  localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;
  localparam logic [55:0] DIV_D = 56'h0000C90FDAA221;
  localparam logic [55:0] DIV_D2 = 56'h0001921FB54442;
  localparam logic [14:0] FULL_RIGHT = 15'd11520;

  typedef struct packed {
    logic        zr;
    logic        ng;
    logic [15:0] nm;
  } side_t;

  function automatic logic [63:0] odd_div(input logic [63:0] p, input int k);
    logic [63:0] t;
    case (k)
      0: t = p;
      1: t = p / 64'd3;
      2: t = p / 64'd5;
      3: t = p / 64'd7;
      4: t = p / 64'd9;
      5: t = p / 64'd11;
      6: t = p / 64'd13;
      7: t = p / 64'd15;
      8: t = p / 64'd17;
      9: t = p / 64'd19;
      10: t = p / 64'd21;
      11: t = p / 64'd23;
      12: t = p / 64'd25;
      13: t = p / 64'd27;
      14: t = p / 64'd29;
      15: t = p / 64'd31;
      16: t = p / 64'd33;
      17: t = p / 64'd35;
      18: t = p / 64'd37;
      19: t = p / 64'd39;
      20: t = p / 64'd41;
      21: t = p / 64'd43;
      22: t = p / 64'd45;
      23: t = p / 64'd47;
      24: t = p / 64'd49;
      25: t = p / 64'd51;
      26: t = p / 64'd53;
      27: t = p / 64'd55;
      28: t = p / 64'd57;
      29: t = p / 64'd59;
      default: t = 64'd0;
    endcase
    return t;
  endfunction

  function automatic logic [63:0] atan_val(input int i);
    logic [63:0] acc;
    int e;
    acc = 64'd0;
    if (i == 0) begin
      acc = PI4_Q60;
    end else begin
      for (int k = 0; k < 30; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          if ((k % 2) == 0) begin
            acc = acc + odd_div(64'd1 << e, k);
          end else begin
            acc = acc - odd_div(64'd1 << e, k);
          end
        end
      end
    end
    return acc;
  endfunction

endpackage

// File: rtl/atrp_tilt.sv
// One tilt angle pipeline: normalize, root, CORDIC arctangent and degree conversion.
module atrp_tilt (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] num_mag,
  input  logic        num_neg,
  input  logic [15:0] mag_a,
  input  logic [15:0] mag_b,
  output logic [14:0] angle
);

  logic [15:0] m_or;
  logic [3:0]  lz;
  logic [15:0] nm1, ma1, mb1;
  logic        zr1, ng1;
  logic [31:0] sa2, sb2;
  atrp_pkg::side_t side2;
  logic [31:0] s3;
  atrp_pkg::side_t side3;

  always_comb begin
    m_or = num_mag | mag_a | mag_b;
    lz = 4'd0;
    for (int b = 0; b < 14; b++) begin
      if (m_or[b]) lz = 4'(14 - b);
    end
    if (m_or[15] || m_or[14]) lz = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm1 <= num_mag << lz;
      ma1 <= mag_a << lz;
      mb1 <= mag_b << lz;
      zr1 <= (m_or == 16'd0);
      ng1 <= num_neg;
      sa2 <= ma1 * ma1;
      sb2 <= mb1 * mb1;
      side2 <= '{zr: zr1, ng: ng1, nm: nm1};
      s3 <= sa2 + sb2;
      side3 <= side2;
    end
  end

  logic [63:0] rad [0:atrp_pkg::SQ_STEPS];
  logic [33:0] rem [0:atrp_pkg::SQ_STEPS];
  logic [31:0] root [0:atrp_pkg::SQ_STEPS];
  atrp_pkg::side_t sside [0:atrp_pkg::SQ_STEPS];

  assign rad[0] = {s3, 32'd0};
  assign rem[0] = 34'd0;
  assign root[0] = 32'd0;
  assign sside[0] = side3;

  for (genvar j = 0; j < atrp_pkg::SQ_STEPS; j++) begin : g_sqrt
    logic [35:0] cur, trial;
    assign cur = {rem[j], rad[j][63:62]};
    assign trial = {2'b00, root[j], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        rad[j+1] <= {rad[j][61:0], 2'b00};
        sside[j+1] <= sside[j];
        if (cur >= trial) begin
          rem[j+1] <= 34'(cur - trial);
          root[j+1] <= {root[j][30:0], 1'b1};
        end else begin
          rem[j+1] <= cur[33:0];
          root[j+1] <= {root[j][30:0], 1'b0};
        end
      end
    end
  end

  logic signed [35:0] cx [0:atrp_pkg::CORDIC_STEPS];
  logic signed [35:0] cy [0:atrp_pkg::CORDIC_STEPS];
  logic signed [63:0] cz [0:atrp_pkg::CORDIC_STEPS];
  atrp_pkg::side_t    cside [0:atrp_pkg::CORDIC_STEPS];

  assign cx[0] = {4'd0, root[atrp_pkg::SQ_STEPS]};
  assign cy[0] = {4'd0, sside[atrp_pkg::SQ_STEPS].nm, 16'd0};
  assign cz[0] = 64'sd0;
  assign cside[0] = sside[atrp_pkg::SQ_STEPS];

  for (genvar i = 0; i < atrp_pkg::CORDIC_STEPS; i++) begin : g_cordic
    localparam logic [63:0] ANG = atrp_pkg::atan_val(i);
    logic signed [35:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        cside[i+1] <= cside[i];
        if (!cy[i][35]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + $signed(ANG);
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - $signed(ANG);
        end
      end
    end
  end

  logic [63:0] zc;
  logic [55:0] qv;
  logic [55:0] nsum;
  logic [55:0] drem [0:atrp_pkg::DIV_BITS];
  logic [14:0] dq [0:atrp_pkg::DIV_BITS];
  logic        dsat [0:atrp_pkg::DIV_BITS];
  atrp_pkg::side_t dside [0:atrp_pkg::DIV_BITS];

  always_comb begin
    zc = cz[atrp_pkg::CORDIC_STEPS][63] ? 64'd0 : cz[atrp_pkg::CORDIC_STEPS];
    qv = {15'd0, zc[60:20]};
    nsum = (qv << 13) + (qv << 11) + (qv << 10) + (qv << 8) + atrp_pkg::DIV_D;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= nsum;
      dsat[0] <= (nsum >= (atrp_pkg::DIV_D2 << atrp_pkg::DIV_BITS));
      dq[0] <= 15'd0;
      dside[0] <= cside[atrp_pkg::CORDIC_STEPS];
    end
  end

  for (genvar t = 0; t < atrp_pkg::DIV_BITS; t++) begin : g_div
    localparam logic [55:0] DSH = atrp_pkg::DIV_D2 << (atrp_pkg::DIV_BITS - 1 - t);
    always_ff @(posedge clk) begin
      if (en) begin
        dsat[t+1] <= dsat[t];
        dside[t+1] <= dside[t];
        if (drem[t] >= DSH) begin
          drem[t+1] <= drem[t] - DSH;
          dq[t+1] <= {dq[t][13:0], 1'b1};
        end else begin
          drem[t+1] <= drem[t];
          dq[t+1] <= {dq[t][13:0], 1'b0};
        end
      end
    end
  end

  logic [14:0] mag;

  always_comb begin
    mag = dq[atrp_pkg::DIV_BITS];
    if (dsat[atrp_pkg::DIV_BITS] || mag > atrp_pkg::FULL_RIGHT) mag = atrp_pkg::FULL_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dside[atrp_pkg::DIV_BITS].zr) begin
        angle <= 15'd0;
      end else if (dside[atrp_pkg::DIV_BITS].ng) begin
        angle <= 15'd0 - mag;
      end else begin
        angle <= mag;
      end
    end
  end

endmodule

// File: rtl/accel_tilt_roll_pitch_unit.sv
// Top level: roll and pitch tilt angles from a three-axis accelerometer word.
// The path from input word to output word runs through the 32-step root,
// the 32-step CORDIC and the 15-step degree division.
// Throughput is one word per cycle; all stages advance together when the output
// register is empty or being taken.
// Synchronous reset clears the valid bits only; data registers are not reset.
module accel_tilt_roll_pitch_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // roll_angle [14:0], pitch_angle [29:15], zero [31:30]
);

  logic                        en;
  logic [atrp_pkg::TILT_LAT-1:0] vld;
  logic [15:0]                 ax, ay, az;
  logic [15:0]                 rx, ry, rz;
  logic                        nx, ny, px_neg;
  logic [14:0]                 roll_angle, pitch_angle;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[atrp_pkg::TILT_LAT-1];

  assign rx = s_tdata[15:0];
  assign ry = s_tdata[31:16];
  assign rz = s_tdata[47:32];
  assign nx = rx[15];
  assign ny = ry[15];
  assign ax = nx ? 16'd0 - rx : rx;
  assign ay = ny ? 16'd0 - ry : ry;
  assign az = rz[15] ? 16'd0 - rz : rz;
  assign px_neg = !nx && (ax != 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[atrp_pkg::TILT_LAT-2:0], s_tvalid};
    end
  end

  atrp_tilt u_roll (
    .clk(clk), .en(en), .num_mag(ay), .num_neg(ny), .mag_a(ax), .mag_b(az),
    .angle(roll_angle)
  );

  atrp_tilt u_pitch (
    .clk(clk), .en(en), .num_mag(ax), .num_neg(px_neg), .mag_a(ay), .mag_b(az),
    .angle(pitch_angle)
  );

  assign m_tdata = {2'b00, pitch_angle, roll_angle};

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready does not follow output stall");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(roll_angle) <= 15'sd11520 && $signed(roll_angle) >= -15'sd11520))
    else $error("roll angle out of range");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(pitch_angle) <= 15'sd11520 && $signed(pitch_angle) >= -15'sd11520))
    else $error("pitch angle out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

// File: verif/tilt_checker.sv
// Checker that predicts roll and pitch for each accepted sample and compares results.
`timescale 1ns / 100ps
module tilt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [14:0] roll;
    logic [14:0] pitch;
  } angles_t;

  angles_t angle_q[$];
  logic [63:0] atan_rom[32];

  initial begin
    logic [63:0] acc;
    int e;
    atan_rom[0] = 64'h0C90FDAA22168C23;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          if (k % 2 == 0) acc = acc + ((64'd1 << e) / (2 * k + 1));
          else acc = acc - ((64'd1 << e) / (2 * k + 1));
        end
      end
      atan_rom[i] = acc;
    end
  end

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [14:0] tilt_angle(input logic [63:0] nm, input logic neg,
                                             input logic [63:0] ma, input logic [63:0] mb);
    logic [63:0] m, s, q, d, mag;
    logic signed [63:0] x, y, z, dx, dy;
    m = nm | ma | mb;
    if (m == 0) return 15'd0;
    while (m < 64'h4000) begin
      m = m << 1; nm = nm << 1; ma = ma << 1; mb = mb << 1;
    end
    s = ma * ma + mb * mb;
    x = root64(s << 32);
    y = nm << 16;
    z = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_rom[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_rom[i];
      end
    end
    if (z < 0) z = 0;
    q = z >> 20;
    d = 64'h0C90FDAA22168C23 >> 20;
    mag = (2 * q * 64'd5760 + d) / (2 * d);
    if (mag > 11520) mag = 11520;
    return neg ? 15'(-mag) : 15'(mag);
  endfunction

  function automatic logic [63:0] mag_of(input logic [15:0] v);
    return v[15] ? 64'h10000 - v : {48'd0, v};
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    logic [63:0] ax, ay, az;
    if (rst) begin
      errors = 0;
      angle_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        ax = mag_of(s_tdata[15:0]);
        ay = mag_of(s_tdata[31:16]);
        az = mag_of(s_tdata[47:32]);
        want.roll = tilt_angle(ay, s_tdata[31], ax, az);
        want.pitch = tilt_angle(ax, !s_tdata[15] && ax != 0, ay, az);
        angle_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (angle_q.size() == 0) begin
          report("result word with no sample pending");
        end else begin
          want = angle_q.pop_front();
          if (m_tdata[14:0] !== want.roll)
            report($sformatf("roll %0d, want %0d", $signed(m_tdata[14:0]),
                             $signed(want.roll)));
          if (m_tdata[29:15] !== want.pitch)
            report($sformatf("pitch %0d, want %0d", $signed(m_tdata[29:15]),
                             $signed(want.pitch)));
          if (m_tdata[31:30] !== 2'b00) report("nonzero pad bits");
        end
      end
    end
    pending = angle_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the tilt testbench: clock, reset, sample stimulus and the verdict.
`timescale 1ns / 100ps
module testbench;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          calm;

  accel_tilt_roll_pitch_unit dut (.*);
  tilt_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        m_tready <= 0;
        repeat (burst) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 8) - 4);
      3: return 16'(2048 - $urandom_range(0, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] edge_vals[6];
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    calm = 0;
    edge_vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h0800);
    send_sample(16'h0800, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h0000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000, 16'h0001);
    send_sample(16'h0001, 16'hFFFF, 16'h0000);
    send_sample(16'h0100, 16'h0100, 16'h0100);
    send_sample(16'hF800, 16'h0800, 16'h0800);
    for (int i = 0; i < 12; i++)
      send_sample(edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)],
                  edge_vals[$urandom_range(0, 5)]);
    for (int i = 0; i < 800; i++) begin
      if (i == 650) calm = 1;
      send_sample(pick_axis(), pick_axis(), pick_axis());
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
